### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ZZ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ZZ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/zz_pkg.sv
`timescale 1ns / 1ps

package zz_pkg;

	localparam int DIM_REG_W   = 4;
	localparam int DIM_LIMIT   = 2 ** DIM_REG_W - 1;
	localparam int VALUE_W     = 16;
	localparam int MAX_RESULTS = 64;
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_SEL_BIT = 2;

	localparam logic                 REG_ROWS  = 1'b0;
	localparam logic                 REG_COLS  = 1'b1;
	localparam logic [DIM_REG_W-1:0] DIM_RESET = DIM_REG_W'(8);

	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_EMIT = 2'b10
	} zz_state_t;

	typedef struct packed {
		logic busy;
		logic issue;
		logic last;
	} zz_walk_st_t;

	typedef struct packed {
		logic [1:0] level;
		logic       pop;
	} zz_q_st_t;

endpackage

### hdl/zigzag_scan_reorder.sv
// A request is taken while the block is loading; the first result of a matrix passes through
// the walker's busy flag, the registered buffer read and the output queue before it is valid.
// Throughput: one result per cycle out of the 1R1W buffer memory while out_stall is low; each
// matrix takes rows*cols loads, then rows*cols reads capped at MAX_RESULTS, plus pipeline and
// turnaround. Input stalls from the emit state after the completing request until the walk is
// done and the output queue has drained. Reset: rows and cols return to 8, the load count clears; buffer kept.
`timescale 1ns / 1ps

module zigzag_scan_reorder #(
	parameter int MAX_DIM    = 8,
	parameter int ELEM_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [zz_pkg::CFG_ADDR_W-1:0]        paddr,
	input  logic [zz_pkg::CFG_DATA_W-1:0]        pwdata,
	output logic [zz_pkg::CFG_DATA_W-1:0]        prdata,
	output logic                                 pready,
	input  logic                                 elem_valid,
	output logic                                 elem_stall,
	input  logic signed [zz_pkg::VALUE_W-1:0]    elem_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [zz_pkg::VALUE_W-1:0]    out_value,
	output logic                                 last
);
	import zz_pkg::*;

	`include "assert_macros.svh"

	localparam int DMAX   = (MAX_DIM < DIM_LIMIT) ? MAX_DIM : DIM_LIMIT;
	localparam int SW     = (ELEM_WIDTH < VALUE_W) ? ELEM_WIDTH : VALUE_W;
	localparam int DEPTH  = DMAX * DMAX;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DIM_W  = $clog2(DMAX + 1);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	logic [DIM_REG_W-1:0] rows_q;
	logic [DIM_REG_W-1:0] cols_q;
	zz_state_t            state_q;
	logic [CNT_W-1:0]     load_cnt_q;
	logic                 inflight_s1;
	logic                 last_s1;

	logic [DIM_W-1:0]     nr;
	logic [DIM_W-1:0]     nc;
	logic [CNT_W-1:0]     total;
	logic [CNT_W-1:0]     lim;
	logic [CNT_W-1:0]     cnt_inc;
	logic                 elem_accept;
	logic                 start_emit;
	logic                 cfg_write;
	logic                 can_issue;
	logic [2:0]           occ;
	logic                 drained;
	logic [ADDR_W-1:0]    rd_addr;
	logic [SW-1:0]        rd_data;
	logic signed [VALUE_W-1:0] push_value;
	zz_walk_st_t          walk_st;
	zz_q_st_t             q_st;

	// configuration
	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready;
	assign prdata    = (paddr[CFG_SEL_BIT] == REG_COLS) ? CFG_DATA_W'(cols_q)
	                                                    : CFG_DATA_W'(rows_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= DIM_RESET;
			cols_q <= DIM_RESET;
		end else if (cfg_write) begin
			if (paddr[CFG_SEL_BIT] == REG_ROWS) begin
				rows_q <= pwdata[DIM_REG_W-1:0];
			end else begin
				cols_q <= pwdata[DIM_REG_W-1:0];
			end
		end
	end

	// clamp dimensions
	always_comb begin
		if (rows_q == '0) begin
			nr = DIM_W'(1);
		end else if (rows_q > DIM_REG_W'(DMAX)) begin
			nr = DIM_W'(DMAX);
		end else begin
			nr = DIM_W'(rows_q);
		end
		if (cols_q == '0) begin
			nc = DIM_W'(1);
		end else if (cols_q > DIM_REG_W'(DMAX)) begin
			nc = DIM_W'(DMAX);
		end else begin
			nc = DIM_W'(cols_q);
		end
	end

	assign total = CNT_W'(nr * nc);
	assign lim   = (int'(total) > MAX_RESULTS) ? CNT_W'(MAX_RESULTS) : total;

	// load side
	assign elem_stall  = (state_q != ST_LOAD);
	assign elem_accept = elem_valid & ~elem_stall;
	assign cnt_inc     = load_cnt_q + CNT_W'(1);
	assign start_emit  = elem_accept && (cnt_inc >= total);

	// emit side: issue a read only when the queue has room for it
	assign occ       = 3'(q_st.level) + 3'(inflight_s1);
	assign can_issue = (occ < (q_st.pop ? 3'd3 : 3'd2));
	assign drained   = !walk_st.busy && !inflight_s1 && (q_st.level == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			load_cnt_q  <= '0;
			inflight_s1 <= 1'b0;
		end else begin
			inflight_s1 <= walk_st.issue;
			if (elem_accept) begin
				load_cnt_q <= start_emit ? '0 : cnt_inc;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (start_emit) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (drained) begin
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (walk_st.issue) begin
			last_s1 <= walk_st.last;
		end
	end

	zz_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W),
		.DATA_W (SW)
	) u_store (
		.clk   (clk),
		.we    (elem_accept && (load_cnt_q < CNT_W'(DEPTH))),
		.waddr (load_cnt_q[ADDR_W-1:0]),
		.wdata (elem_value[SW-1:0]),
		.re    (walk_st.issue),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	zz_walk #(
		.DIM_W  (DIM_W),
		.ADDR_W (ADDR_W),
		.CNT_W  (CNT_W)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_emit),
		.nr        (nr),
		.nc        (nc),
		.lim       (lim),
		.can_issue (can_issue),
		.addr      (rd_addr),
		.st        (walk_st)
	);

	assign push_value = VALUE_W'(signed'(rd_data));

	zz_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (inflight_s1),
		.push_value (push_value),
		.push_last  (last_s1),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_value  (out_value),
		.last       (last),
		.st         (q_st)
	);

	`ZZ_ASSERT_IMP(a_out_in_emit, out_valid, state_q == ST_EMIT, "result outside emit phase")
	`ZZ_ASSERT_IMP(a_no_load_in_walk, walk_st.busy || inflight_s1, !elem_accept, "load during emit")
	`ZZ_ASSERT_NXT(a_emit_follows, start_emit, (state_q == ST_EMIT) && walk_st.busy, "emit not started")

endmodule

### hdl/zz_store.sv
`timescale 1ns / 1ps

module zz_store #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/zz_walk.sv
`timescale 1ns / 1ps

module zz_walk #(
	parameter int DIM_W  = 4,
	parameter int ADDR_W = 6,
	parameter int CNT_W  = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIM_W-1:0]    nr,
	input  logic [DIM_W-1:0]    nc,
	input  logic [CNT_W-1:0]    lim,
	input  logic                can_issue,
	output logic [ADDR_W-1:0]   addr,
	output zz_pkg::zz_walk_st_t st
);
	import zz_pkg::*;

	`include "assert_macros.svh"

	logic              busy_q;
	logic              odd_q;
	logic [DIM_W-1:0]  r_q;
	logic [DIM_W-1:0]  c_q;
	logic [ADDR_W-1:0] base_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIM_W-1:0]  nr_q;
	logic [DIM_W-1:0]  nc_q;
	logic [CNT_W-1:0]  lim_q;

	logic              odd_n;
	logic [DIM_W-1:0]  r_n;
	logic [DIM_W-1:0]  c_n;
	logic [ADDR_W-1:0] base_n;
	logic              issue;
	logic              last;

	assign issue = busy_q & can_issue;
	assign last  = ((cnt_q + CNT_W'(1)) == lim_q);
	assign addr  = base_q + ADDR_W'(c_q);

	assign st.busy  = busy_q;
	assign st.issue = issue;
	assign st.last  = last;

	always_comb begin
		r_n    = r_q;
		c_n    = c_q;
		base_n = base_q;
		odd_n  = odd_q;
		if (odd_q) begin
			if (r_q == nr_q - DIM_W'(1)) begin
				c_n   = c_q + DIM_W'(1);
				odd_n = 1'b0;
			end else if (c_q == '0) begin
				r_n    = r_q + DIM_W'(1);
				base_n = base_q + ADDR_W'(nc_q);
				odd_n  = 1'b0;
			end else begin
				r_n    = r_q + DIM_W'(1);
				c_n    = c_q - DIM_W'(1);
				base_n = base_q + ADDR_W'(nc_q);
			end
		end else begin
			if (c_q == nc_q - DIM_W'(1)) begin
				r_n    = r_q + DIM_W'(1);
				base_n = base_q + ADDR_W'(nc_q);
				odd_n  = 1'b1;
			end else if (r_q == '0) begin
				c_n   = c_q + DIM_W'(1);
				odd_n = 1'b1;
			end else begin
				r_n    = r_q - DIM_W'(1);
				c_n    = c_q + DIM_W'(1);
				base_n = base_q - ADDR_W'(nc_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (issue && last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q    <= '0;
			c_q    <= '0;
			base_q <= '0;
			odd_q  <= 1'b0;
			cnt_q  <= '0;
			nr_q   <= nr;
			nc_q   <= nc;
			lim_q  <= lim;
		end else if (issue) begin
			r_q    <= r_n;
			c_q    <= c_n;
			base_q <= base_n;
			odd_q  <= odd_n;
			cnt_q  <= cnt_q + CNT_W'(1);
		end
	end

	`ZZ_ASSERT_IMP(a_pos_in_bounds, busy_q, (r_q < nr_q) && (c_q < nc_q), "walk left the matrix")

endmodule

### hdl/zz_outq.sv
`timescale 1ns / 1ps

module zz_outq (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  logic signed [zz_pkg::VALUE_W-1:0] push_value,
	input  logic                             push_last,
	input  logic                             out_stall,
	output logic                             out_valid,
	output logic signed [zz_pkg::VALUE_W-1:0] out_value,
	output logic                             last,
	output zz_pkg::zz_q_st_t                 st
);
	import zz_pkg::*;

	`include "assert_macros.svh"

	logic signed [VALUE_W-1:0] val_q [2];
	logic                      lst_q [2];
	logic                      rd_q;
	logic                      wr_q;
	logic [1:0]                level_q;
	logic                      pop;

	assign out_valid = (level_q != 2'd0);
	assign out_value = val_q[rd_q];
	assign last      = lst_q[rd_q];
	assign pop       = out_valid & ~out_stall;

	assign st.level = level_q;
	assign st.pop   = pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= 1'b0;
			wr_q    <= 1'b0;
			level_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			unique case ({push, pop})
				2'b10:   level_q <= level_q + 2'd1;
				2'b01:   level_q <= level_q - 2'd1;
				default: level_q <= level_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			val_q[wr_q] <= push_value;
			lst_q[wr_q] <= push_last;
		end
	end

	`ZZ_ASSERT_IMP(a_no_overflow, push && !pop, level_q != 2'd2, "output queue overflow")

endmodule
